[rtl/trm_pkg.sv]
// ----------------------------------------------------------------------------
// trm_pkg: shared types and constants for the touchpad relative motion block
// Holds the field widths, the millimetre divisor and the report mode codes.
// ----------------------------------------------------------------------------
`default_nettype none

package trm_pkg;

   // Fixed widths of the request and response fields.
   localparam int COUNT_BITS       = 4;
   localparam int ID_BITS          = 8;
   localparam int FIELD_COORD_BITS = 16;
   localparam int REL_BITS         = 11;

   // Coordinates come in units of ten micrometres; motion goes out in millimetres.
   localparam int DIVISOR          = 100;
   // Smallest shift with 2**shift >= DIVISOR, used to size the reciprocal.
   localparam int DIV_EXTRA_SHIFT  = 7;

   // Saturation limits of the signed motion fields.
   localparam int REL_POS_LIMIT    = 1023;
   localparam int REL_NEG_LIMIT    = 1024;

   // What the block does with the contacts of the current report.
   typedef enum logic {
      MODE_SEARCH = 1'b0,
      MODE_IGNORE = 1'b1
   } mode_type;

endpackage

`default_nettype wire

[rtl/touchpad_relative_motion_core.sv]
// ----------------------------------------------------------------------------
// touchpad_relative_motion_core: multi-touch contacts to relative pointer motion
// Tracks one finger across reports and returns its motion in millimetres.
// ----------------------------------------------------------------------------
// Usage:
//   Requests carry one contact each. A report is a run of requests closed by
//   the one with req_last_in_report set; a first request with a contact count
//   of zero is a report on its own and means every finger is lifted.
//   Each report produces exactly one response, holding the tracked finger's
//   motion and the primary button, or all zeros when there is nothing to
//   report (new touch, finger missing, all lifted).
//   Both channels use valid and stall; a transfer happens on a rising edge
//   with valid high and stall low.
//   One request per cycle is accepted while req_stall is low. The path is an
//   input register, the tracking state update, a magnitude register, a
//   reciprocal multiply register and the saturated response register.
//   Stalls: rsp_stall holds the response register; the stages behind it keep
//   filling bubbles first, and req_stall rises only when every stage is full.
//   Reset (synchronous, active high) empties the pipeline and clears the
//   tracking state so the next request starts a fresh report.
// ----------------------------------------------------------------------------
`default_nettype none

module touchpad_relative_motion_core #(
   parameter int COORD_BITS = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   // Request channel.
   input  wire logic                                     req_valid,
   output logic                                          req_stall,
   input  wire logic [trm_pkg::COUNT_BITS-1:0]           req_contact_count,
   input  wire logic [trm_pkg::ID_BITS-1:0]              req_contact_id,
   input  wire logic [trm_pkg::FIELD_COORD_BITS-1:0]     req_contact_x,
   input  wire logic [trm_pkg::FIELD_COORD_BITS-1:0]     req_contact_y,
   input  wire logic                                     req_button_down,
   input  wire logic                                     req_last_in_report,
   // Response channel.
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_stall,
   output logic signed [trm_pkg::REL_BITS-1:0]           rsp_rel_x,
   output logic signed [trm_pkg::REL_BITS-1:0]           rsp_rel_y,
   output logic                                          rsp_primary_pressed
);

   // Quotient width: a COORD_BITS magnitude over the divisor.
   localparam int QW = COORD_BITS - trm_pkg::DIV_EXTRA_SHIFT + 1;
   // Rounded-up reciprocal; exact floor division for every COORD_BITS magnitude.
   localparam logic [COORD_BITS:0] RECIP = (COORD_BITS + 1)'(
      ((64'd1 << (COORD_BITS + trm_pkg::DIV_EXTRA_SHIFT)) + 64'(trm_pkg::DIVISOR - 1))
      / 64'(trm_pkg::DIVISOR));
   localparam int PROD_BITS = 2 * COORD_BITS + 1;

   // ------------------------------------------------------------------------
   // Declarations
   // ------------------------------------------------------------------------
   // Input register.
   logic                               a_valid_ff;
   logic [trm_pkg::COUNT_BITS-1:0]     a_count_ff;
   logic [trm_pkg::ID_BITS-1:0]        a_id_ff;
   logic [COORD_BITS-1:0]              a_x_ff;
   logic [COORD_BITS-1:0]              a_y_ff;
   logic                               a_button_ff;
   logic                               a_last_ff;

   // Tracking state.
   logic                               touching_ff, touching_in;
   logic                               lifted_ff, lifted_in;
   logic [trm_pkg::ID_BITS-1:0]        tracked_id_ff, tracked_id_in;
   logic [COORD_BITS-1:0]              anchor_x_ff, anchor_x_in;
   logic [COORD_BITS-1:0]              anchor_y_ff, anchor_y_in;
   logic                               start_ff, start_in;
   trm_pkg::mode_type                  mode_ff, mode_in;
   logic                               found_ff, found_in;
   logic [COORD_BITS-1:0]              match_x_ff, match_x_in;
   logic [COORD_BITS-1:0]              match_y_ff, match_y_in;

   // Per-request decode.
   logic                               start_zero;
   trm_pkg::mode_type                  mode_eff;
   logic                               found_eff;
   logic                               hit;
   logic                               found_now;
   logic [COORD_BITS-1:0]              mx, my;
   logic [COORD_BITS-1:0]              base_x, base_y;
   logic [COORD_BITS:0]                diff_x, diff_y;
   logic [COORD_BITS:0]                neg_x, neg_y;
   logic                               emit;

   // Magnitude stage.
   logic                               b_valid_ff;
   logic                               b_sign_x_ff, b_sign_x_in;
   logic                               b_sign_y_ff, b_sign_y_in;
   logic [COORD_BITS-1:0]              b_mag_x_ff, b_mag_x_in;
   logic [COORD_BITS-1:0]              b_mag_y_ff, b_mag_y_in;
   logic                               b_button_ff, b_button_in;

   // Quotient stage.
   logic                               c_valid_ff;
   logic                               c_sign_x_ff, c_sign_y_ff;
   logic [QW-1:0]                      c_q_x_ff, c_q_y_ff;
   logic                               c_button_ff;
   logic [PROD_BITS-1:0]               prod_x, prod_y;

   // Response register.
   logic                               rsp_valid_ff;
   logic signed [trm_pkg::REL_BITS-1:0] rel_x_ff, rel_y_ff;
   logic                               button_ff;

   // Handshake chain.
   logic                               out_ready, c_ready, b_ready, a_ready, a_fire;

   // ------------------------------------------------------------------------
   // Stage advance: a stage loads when it is empty or its content moves on.
   // ------------------------------------------------------------------------
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign c_ready   = !c_valid_ff || out_ready;
   assign b_ready   = !b_valid_ff || c_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign a_fire    = a_valid_ff && b_ready;
   assign req_stall = !a_ready;

   // Input register captures each accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= req_valid;
      end
      if (a_ready && req_valid) begin
         a_count_ff  <= req_contact_count;
         a_id_ff     <= req_contact_id;
         a_x_ff      <= COORD_BITS'(req_contact_x);
         a_y_ff      <= COORD_BITS'(req_contact_y);
         a_button_ff <= req_button_down;
         a_last_ff   <= req_last_in_report;
      end
   end

   // ------------------------------------------------------------------------
   // Contact decode: report start handling and the tracked id search.
   // ------------------------------------------------------------------------
   assign start_zero = start_ff && (a_count_ff == '0);
   assign mode_eff   = start_ff ? (touching_ff ? trm_pkg::MODE_SEARCH : trm_pkg::MODE_IGNORE)
                                : mode_ff;
   assign found_eff  = start_ff ? 1'b0 : found_ff;
   assign hit        = !start_zero && (mode_eff == trm_pkg::MODE_SEARCH) && !found_eff
                       && (a_id_ff == tracked_id_ff);
   assign found_now  = found_eff || hit;
   assign mx         = hit ? a_x_ff : match_x_ff;
   assign my         = hit ? a_y_ff : match_y_ff;

   // After a lift the anchor reseeds from the captured contact, giving zero motion.
   assign base_x = lifted_ff ? mx : anchor_x_ff;
   assign base_y = lifted_ff ? my : anchor_y_ff;
   assign diff_x = {1'b0, mx} - {1'b0, base_x};
   assign diff_y = {1'b0, my} - {1'b0, base_y};
   assign neg_x  = -diff_x;
   assign neg_y  = -diff_y;

   // Next tracking state and the magnitude stage payload.
   always_comb begin
      touching_in   = touching_ff;
      lifted_in     = lifted_ff;
      tracked_id_in = tracked_id_ff;
      anchor_x_in   = anchor_x_ff;
      anchor_y_in   = anchor_y_ff;
      start_in      = start_ff;
      mode_in       = mode_ff;
      found_in      = found_ff;
      match_x_in    = match_x_ff;
      match_y_in    = match_y_ff;
      emit          = 1'b0;
      b_sign_x_in   = 1'b0;
      b_sign_y_in   = 1'b0;
      b_mag_x_in    = '0;
      b_mag_y_in    = '0;
      b_button_in   = 1'b0;

      if (start_zero) begin
         // All fingers lifted: a whole report on its own with a zero response.
         touching_in = 1'b0;
         lifted_in   = 1'b1;
         mode_in     = trm_pkg::MODE_SEARCH;
         found_in    = 1'b0;
         emit        = 1'b1;
      end else begin
         // A new touch takes the first contact as the tracked finger.
         if (start_ff) begin
            start_in = 1'b0;
            if (!touching_ff) begin
               touching_in   = 1'b1;
               lifted_in     = 1'b0;
               tracked_id_in = a_id_ff;
               anchor_x_in   = a_x_ff;
               anchor_y_in   = a_y_ff;
            end
         end

         if (a_last_ff) begin
            // Report closes: one response, then back to searching.
            start_in = 1'b1;
            emit     = 1'b1;
            mode_in  = trm_pkg::MODE_SEARCH;
            found_in = 1'b0;
            if (mode_eff == trm_pkg::MODE_SEARCH) begin
               if (!found_now) begin
                  lifted_in = 1'b1;
               end else begin
                  lifted_in   = 1'b0;
                  anchor_x_in = mx;
                  anchor_y_in = my;
                  b_sign_x_in = diff_x[COORD_BITS];
                  b_sign_y_in = diff_y[COORD_BITS];
                  b_mag_x_in  = diff_x[COORD_BITS] ? neg_x[COORD_BITS-1:0]
                                                   : diff_x[COORD_BITS-1:0];
                  b_mag_y_in  = diff_y[COORD_BITS] ? neg_y[COORD_BITS-1:0]
                                                   : diff_y[COORD_BITS-1:0];
                  b_button_in = a_button_ff;
               end
            end
         end else begin
            mode_in    = mode_eff;
            found_in   = found_now;
            match_x_in = mx;
            match_y_in = my;
         end
      end
   end

   // Tracking state advances when the input register hands its request on.
   always_ff @(posedge clock) begin
      if (reset) begin
         touching_ff   <= 1'b0;
         lifted_ff     <= 1'b0;
         tracked_id_ff <= '0;
         anchor_x_ff   <= '0;
         anchor_y_ff   <= '0;
         start_ff      <= 1'b1;
         mode_ff       <= trm_pkg::MODE_SEARCH;
         found_ff      <= 1'b0;
         match_x_ff    <= '0;
         match_y_ff    <= '0;
      end else if (a_fire) begin
         touching_ff   <= touching_in;
         lifted_ff     <= lifted_in;
         tracked_id_ff <= tracked_id_in;
         anchor_x_ff   <= anchor_x_in;
         anchor_y_ff   <= anchor_y_in;
         start_ff      <= start_in;
         mode_ff       <= mode_in;
         found_ff      <= found_in;
         match_x_ff    <= match_x_in;
         match_y_ff    <= match_y_in;
      end
   end

   // Magnitude stage holds sign and absolute delta of a report's response.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff && emit;
      end
      if (a_fire) begin
         b_sign_x_ff <= b_sign_x_in;
         b_sign_y_ff <= b_sign_y_in;
         b_mag_x_ff  <= b_mag_x_in;
         b_mag_y_ff  <= b_mag_y_in;
         b_button_ff <= b_button_in;
      end
   end

   // ------------------------------------------------------------------------
   // Division by the divisor: multiply by the rounded-up reciprocal and shift.
   // ------------------------------------------------------------------------
   assign prod_x = {{(COORD_BITS + 1){1'b0}}, b_mag_x_ff} * {{COORD_BITS{1'b0}}, RECIP};
   assign prod_y = {{(COORD_BITS + 1){1'b0}}, b_mag_y_ff} * {{COORD_BITS{1'b0}}, RECIP};

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_ready) begin
         c_valid_ff <= b_valid_ff;
      end
      if (c_ready && b_valid_ff) begin
         c_sign_x_ff <= b_sign_x_ff;
         c_sign_y_ff <= b_sign_y_ff;
         c_q_x_ff    <= prod_x[PROD_BITS-1 -: QW];
         c_q_y_ff    <= prod_y[PROD_BITS-1 -: QW];
         c_button_ff <= b_button_ff;
      end
   end

   // Apply the sign and clamp to the signed range of the motion fields.
   function automatic logic [trm_pkg::REL_BITS-1:0] sat_rel(input logic neg,
                                                            input logic [QW-1:0] q);
      logic [31:0] qx;
      qx = 32'(q);
      if (neg) begin
         if (qx > 32'(trm_pkg::REL_NEG_LIMIT)) begin
            sat_rel = trm_pkg::REL_BITS'(-32'(trm_pkg::REL_NEG_LIMIT));
         end else begin
            sat_rel = trm_pkg::REL_BITS'(-qx);
         end
      end else begin
         if (qx > 32'(trm_pkg::REL_POS_LIMIT)) begin
            sat_rel = trm_pkg::REL_BITS'(trm_pkg::REL_POS_LIMIT);
         end else begin
            sat_rel = trm_pkg::REL_BITS'(qx);
         end
      end
   endfunction

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= c_valid_ff;
      end
      if (out_ready && c_valid_ff) begin
         rel_x_ff  <= sat_rel(c_sign_x_ff, c_q_x_ff);
         rel_y_ff  <= sat_rel(c_sign_y_ff, c_q_y_ff);
         button_ff <= c_button_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_rel_x           = rel_x_ff;
   assign rsp_rel_y           = rel_y_ff;
   assign rsp_primary_pressed = button_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // A captured match only exists inside an open report of a touching finger.
   a_found_needs_touch : assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (touching_ff && !start_ff))
      else $error("match held outside an open report");

   // Ignore mode only lasts for the rest of a report that opened a new touch.
   a_ignore_mid_report : assert property (@(posedge clock) disable iff (reset)
      (mode_ff == trm_pkg::MODE_IGNORE) |-> (touching_ff && !start_ff && !found_ff))
      else $error("ignore mode outside a new-touch report");

   // A closing request always passes a response into the magnitude stage.
   a_close_emits : assert property (@(posedge clock) disable iff (reset)
      (a_fire && (a_last_ff || start_zero)) |=> b_valid_ff)
      else $error("closed report produced no response");

   // A held magnitude stage keeps its payload.
   a_b_holds : assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !c_ready) |=> (b_valid_ff && $stable(b_mag_x_ff)
                                    && $stable(b_mag_y_ff)))
      else $error("magnitude stage lost its payload under stall");

endmodule

`default_nettype wire
